// ===== rtl/ahtc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ahtc_pkg
// Shared types and constants for the airspeed hold thrust controller.
// ----------------------------------------------------------------------------
package ahtc_pkg;

    localparam int TGT_W    = 24;
    localparam int DVD_W    = 43;   // |thr + net| * 1000 fits 43 bits
    localparam int LDIV_W   = 16;   // level quotient bits
    localparam int DEN_W    = 47;   // thr * 50000
    localparam int PROD_W   = 72;   // |a| * mass
    localparam int CNT_W    = 6;

    localparam logic signed [30:0] GEAR_GROUND_CM = 31'sd10;
    localparam logic [31:0]        MIN_TIME_MS    = 32'd100;
    localparam logic [16:0]        MAX_TIME_ACCEL = 17'd100;
    localparam logic [23:0]        ACC_MIN_GAIN   = 24'd1000;
    localparam logic [16:0]        LEVEL_ONE      = 17'd65536;
    localparam logic [1:0]         HOLD_UNSET     = 2'd0;
    localparam logic [1:0]         HOLD_OFF       = 2'd1;
    localparam logic [1:0]         HOLD_ON        = 2'd2;

    typedef struct packed {
        logic load;
        logic prep;
        logic div_step;
        logic fin;
        logic lset;
        logic ldiv_step;
        logic write;
    } ahtc_cmd_t;

    typedef struct packed {
        logic noact;
        logic level_path;
        logic need_ldiv;
        logic div_done;
        logic ldiv_done;
        logic out_free;
    } ahtc_status_t;

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_PREP  = 7'b0000010,
        ST_DIV   = 7'b0000100,
        ST_FIN   = 7'b0001000,
        ST_LSET  = 7'b0010000,
        ST_LDIV  = 7'b0100000,
        ST_WRITE = 7'b1000000
    } ahtc_state_t;

endpackage

// ===== rtl/ahtc_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ahtc_ctrl
// Sequencer: steps the datapath through prepare, divide, finish, level divide and write-back.
// ----------------------------------------------------------------------------
module ahtc_ctrl
    import ahtc_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_valid,
    output logic         s_ready,
    input  ahtc_status_t status,
    output ahtc_cmd_t    cmd
);

    ahtc_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_PREP;
                end
            end
            ST_PREP: begin
                cmd.prep   = 1'b1;
                state_next = status.noact ? ST_WRITE : ST_DIV;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (status.div_done) begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                cmd.fin    = 1'b1;
                state_next = ST_LSET;
            end
            ST_LSET: begin
                cmd.lset   = 1'b1;
                state_next = (status.level_path && status.need_ldiv) ? ST_LDIV : ST_WRITE;
            end
            ST_LDIV: begin
                cmd.ldiv_step = 1'b1;
                if (status.ldiv_done) begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE: begin
                // hold until the output register is free
                if (status.out_free) begin
                    cmd.write  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/ahtc_dpath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ahtc_dpath
// Datapath: force sums, serial divider and multiplier, level divider, state.
// ----------------------------------------------------------------------------
module ahtc_dpath
    import ahtc_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  ahtc_cmd_t           cmd,
    output ahtc_status_t        status,
    input  logic                cfg_valid,
    input  logic [TGT_W-1:0]    cfg_wdata,
    input  logic                s_crashed,
    input  logic [31:0]         s_sim_time_ms,
    input  logic                s_hold_engaged,
    input  logic [16:0]         s_time_accel,
    input  logic                s_ground_contact,
    input  logic signed [30:0]  s_gear_altitude_cm,
    input  logic [23:0]         s_mass_kg,
    input  logic [30:0]         s_main_thrust_max,
    input  logic signed [31:0]  s_total_force_z,
    input  logic signed [31:0]  s_thrust_z,
    input  logic signed [31:0]  s_weight_lift_drag_z,
    input  logic [23:0]         s_airspeed_cms,
    output logic                m_valid,
    input  logic                m_ready,
    output logic                m_level_valid,
    output logic [16:0]         m_main_level,
    output logic signed [31:0]  m_max_main_acc,
    output logic                m_max_acc_valid,
    output logic                m_suspended,
    output logic                m_thrust_warning
);

    localparam logic [PROD_W-1:0] PROD_LIMIT = PROD_W'(1) << 62;

    // control state
    logic [TGT_W-1:0] tgt_reg;
    logic [1:0]       prev_hold_reg;
    logic             susp_reg;
    logic             m_valid_reg;
    logic [CNT_W-1:0] cnt_reg;

    // latched item
    logic               crashed_reg, engaged_reg, ground_reg;
    logic [31:0]        simt_reg;
    logic [16:0]        taccel_reg;
    logic signed [30:0] alt_reg;
    logic [23:0]        mass_reg;
    logic [30:0]        thr_reg;
    logic signed [31:0] fz_reg, tz_reg, wld_reg;
    logic [23:0]        air_reg;

    // working registers
    logic [DVD_W-1:0]   dvd_reg;
    logic [23:0]        rem_reg;
    logic [23:0]        mdiv_reg;
    logic               accneg_reg;
    logic [PROD_W-1:0]  mcand_reg;
    logic [23:0]        mplier_reg;
    logic [PROD_W-1:0]  pacc_reg;
    logic               aneg_reg;
    logic signed [49:0] nsc_reg;
    logic [DEN_W-1:0]   den_reg;
    logic               warn_reg;
    logic signed [31:0] acc_reg;
    logic signed [63:0] num_reg;
    logic [DEN_W-1:0]   lrem_reg;
    logic [16:0]        level_reg;

    // output register
    logic               o_level_valid_reg, o_acc_valid_reg, o_susp_reg, o_warn_reg;
    logic [16:0]        o_level_reg;
    logic signed [31:0] o_acc_reg;

    // prepare stage
    logic signed [32:0] net, net_eff;
    logic signed [33:0] sum;
    logic [33:0]        sum_mag;
    logic signed [24:0] d;
    logic [24:0]        d_mag;
    logic [23:0]        ad, mx;
    logic [23:0]        mass_eff;

    // steps
    logic [24:0]        dtrial;
    logic               dge;
    logic [DEN_W:0]     ltrial;
    logic               lge;

    // finish stage
    logic [62:0]        pmag;
    logic signed [63:0] prod;
    logic signed [31:0] acc_sat;
    logic [DVD_W-1:0]   q;

    logic noact, hold_known, susp_cond;

    assign noact      = crashed_reg || (simt_reg < MIN_TIME_MS);
    assign hold_known = engaged_reg && (prev_hold_reg != HOLD_UNSET);
    assign susp_cond  = taccel_reg > MAX_TIME_ACCEL;

    always_comb begin
        net      = (alt_reg <= GEAR_GROUND_CM)
                 ? ($signed({fz_reg[31], fz_reg}) - $signed({tz_reg[31], tz_reg}))
                 : $signed({wld_reg[31], wld_reg});
        sum      = $signed({3'b000, thr_reg}) + $signed({net[32], net});
        sum_mag  = sum[33] ? 34'(-sum) : 34'(sum);
        d        = $signed({1'b0, tgt_reg}) - $signed({1'b0, air_reg});
        d_mag    = d[24] ? 25'(-d) : 25'(d);
        ad       = d_mag[23:0];
        mx       = (ad > ACC_MIN_GAIN) ? ad : ACC_MIN_GAIN;
        net_eff  = (ground_reg && (tgt_reg == '0) && net[32]) ? 33'sd0 : net;
        mass_eff = (mass_reg == '0) ? 24'd1 : mass_reg;
    end

    always_comb begin
        dtrial = {rem_reg, dvd_reg[DVD_W-1]};
        dge    = dtrial >= {1'b0, mdiv_reg};
        ltrial = {lrem_reg, 1'b0};
        lge    = ltrial >= {1'b0, den_reg};
    end

    always_comb begin
        q    = dvd_reg;
        pmag = (pacc_reg > PROD_LIMIT) ? 63'(PROD_LIMIT) : pacc_reg[62:0];
        prod = aneg_reg ? -$signed({1'b0, pmag}) : $signed({1'b0, pmag});
        if (!accneg_reg) begin
            acc_sat = (q > DVD_W'(32'h7fff_ffff)) ? 32'sh7fff_ffff : $signed(q[31:0]);
        end else begin
            acc_sat = (q > DVD_W'(32'h8000_0000)) ? 32'sh8000_0000 : $signed(-q[31:0]);
        end
    end

    always_comb begin
        status.noact      = noact;
        status.level_path = hold_known && !susp_cond;
        status.need_ldiv  = !num_reg[63] && (num_reg != '0) &&
                            (num_reg < $signed({17'b0, den_reg}));
        status.div_done   = cnt_reg == CNT_W'(DVD_W - 1);
        status.ldiv_done  = cnt_reg == CNT_W'(LDIV_W - 1);
        status.out_free   = !m_valid_reg || m_ready;
    end

    // configuration, hold state and output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tgt_reg       <= '0;
            prev_hold_reg <= HOLD_UNSET;
            susp_reg      <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (cfg_valid) begin
                tgt_reg <= cfg_wdata;
            end
            if (cmd.write) begin
                m_valid_reg <= 1'b1;
                if (!noact) begin
                    if (hold_known && susp_cond) begin
                        susp_reg <= 1'b1;
                    end else begin
                        if (hold_known) begin
                            susp_reg <= 1'b0;
                        end
                        prev_hold_reg <= engaged_reg ? HOLD_ON : HOLD_OFF;
                    end
                end
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (cmd.prep || cmd.lset) begin
            cnt_reg <= '0;
        end else if (cmd.div_step || cmd.ldiv_step) begin
            cnt_reg <= cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            crashed_reg <= s_crashed;
            simt_reg    <= s_sim_time_ms;
            engaged_reg <= s_hold_engaged;
            taccel_reg  <= s_time_accel;
            ground_reg  <= s_ground_contact;
            alt_reg     <= s_gear_altitude_cm;
            mass_reg    <= s_mass_kg;
            thr_reg     <= s_main_thrust_max;
            fz_reg      <= s_total_force_z;
            tz_reg      <= s_thrust_z;
            wld_reg     <= s_weight_lift_drag_z;
            air_reg     <= s_airspeed_cms;
        end
        if (cmd.prep) begin
            dvd_reg    <= DVD_W'(sum_mag[32:0]) * DVD_W'(1000);
            rem_reg    <= '0;
            mdiv_reg   <= mass_eff;
            accneg_reg <= sum[33];
            mcand_reg  <= PROD_W'(48'(ad) * 48'(mx));
            mplier_reg <= mass_eff;
            pacc_reg   <= '0;
            aneg_reg   <= d[24];
            nsc_reg    <= $signed({{17{net_eff[32]}}, net_eff}) * 50'sd50000;
            den_reg    <= DEN_W'(thr_reg) * DEN_W'(50000);
            warn_reg   <= sum[33] && (air_reg < tgt_reg);
        end
        if (cmd.div_step) begin
            // restoring divide step, and one step of the shift-add multiply
            rem_reg    <= dge ? 24'(dtrial - {1'b0, mdiv_reg}) : dtrial[23:0];
            dvd_reg    <= {dvd_reg[DVD_W-2:0], dge};
            if (mplier_reg[0]) begin
                pacc_reg <= pacc_reg + mcand_reg;
            end
            mcand_reg  <= mcand_reg << 1;
            mplier_reg <= mplier_reg >> 1;
        end
        if (cmd.fin) begin
            acc_reg <= acc_sat;
            num_reg <= prod - $signed({{14{nsc_reg[49]}}, nsc_reg});
        end
        if (cmd.lset) begin
            lrem_reg <= num_reg[DEN_W-1:0];
            if (num_reg[63] || (num_reg == '0)) begin
                level_reg <= '0;
            end else if (num_reg >= $signed({17'b0, den_reg})) begin
                level_reg <= LEVEL_ONE;
            end else begin
                level_reg <= '0;
            end
        end
        if (cmd.ldiv_step) begin
            lrem_reg  <= lge ? DEN_W'(ltrial - {1'b0, den_reg}) : ltrial[DEN_W-1:0];
            level_reg <= {level_reg[15:0], lge};
        end
        if (cmd.write) begin
            o_level_valid_reg <= !noact && hold_known && !susp_cond;
            o_level_reg       <= (!noact && hold_known && !susp_cond) ? level_reg : '0;
            o_warn_reg        <= !noact && hold_known && !susp_cond && warn_reg;
            o_acc_valid_reg   <= !noact;
            o_acc_reg         <= noact ? 32'sd0 : acc_reg;
            o_susp_reg        <= noact ? susp_reg : (hold_known ? susp_cond : susp_reg);
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_level_valid    = o_level_valid_reg;
    assign m_main_level     = o_level_reg;
    assign m_max_main_acc   = o_acc_reg;
    assign m_max_acc_valid  = o_acc_valid_reg;
    assign m_suspended      = o_susp_reg;
    assign m_thrust_warning = o_warn_reg;

endmodule

// ===== rtl/airspeed_hold_thrust_controller_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// airspeed_hold_thrust_controller_core
// Main engine throttle level for an airspeed hold, one item per control tick.
//
//   channel  | dir | handshake          | carries
//   ---------+-----+--------------------+-------------------------------
//   cfg      | in  | cfg_valid/ready    | target airspeed, cm/s
//   s_       | in  | s_valid/s_ready    | vehicle state for one tick
//   m_       | out | m_valid/m_ready    | level, max acceleration, flags
//
// The acceleration comes from the 43-step restoring divider; ticks on the level
// path that need a fractional level also run the 16-step level divider, and
// no-action ticks skip both. One item is in work at a time; the next is taken
// in the cycle after the result is written.
// A result waits in the output register; the next item can be taken meanwhile.
// Reset is synchronous on aresetn low; target and hold state clear to zero.
// ----------------------------------------------------------------------------
module airspeed_hold_thrust_controller_core
    import ahtc_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [23:0]        cfg_wdata,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_crashed,
    input  logic [31:0]        s_sim_time_ms,
    input  logic               s_hold_engaged,
    input  logic [16:0]        s_time_accel,
    input  logic               s_ground_contact,
    input  logic signed [30:0] s_gear_altitude_cm,
    input  logic [23:0]        s_mass_kg,
    input  logic [30:0]        s_main_thrust_max,
    input  logic signed [31:0] s_total_force_z,
    input  logic signed [31:0] s_thrust_z,
    input  logic signed [31:0] s_weight_lift_drag_z,
    input  logic [23:0]        s_airspeed_cms,
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_level_valid,
    output logic [16:0]        m_main_level,
    output logic signed [31:0] m_max_main_acc,
    output logic               m_max_acc_valid,
    output logic               m_suspended,
    output logic               m_thrust_warning
);

    ahtc_cmd_t    cmd;
    ahtc_status_t status;

    assign cfg_ready = 1'b1;

    ahtc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    ahtc_dpath u_dpath (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .cmd                  (cmd),
        .status               (status),
        .cfg_valid            (cfg_valid),
        .cfg_wdata            (cfg_wdata),
        .s_crashed            (s_crashed),
        .s_sim_time_ms        (s_sim_time_ms),
        .s_hold_engaged       (s_hold_engaged),
        .s_time_accel         (s_time_accel),
        .s_ground_contact     (s_ground_contact),
        .s_gear_altitude_cm   (s_gear_altitude_cm),
        .s_mass_kg            (s_mass_kg),
        .s_main_thrust_max    (s_main_thrust_max),
        .s_total_force_z      (s_total_force_z),
        .s_thrust_z           (s_thrust_z),
        .s_weight_lift_drag_z (s_weight_lift_drag_z),
        .s_airspeed_cms       (s_airspeed_cms),
        .m_valid              (m_valid),
        .m_ready              (m_ready),
        .m_level_valid        (m_level_valid),
        .m_main_level         (m_main_level),
        .m_max_main_acc       (m_max_main_acc),
        .m_max_acc_valid      (m_max_acc_valid),
        .m_suspended          (m_suspended),
        .m_thrust_warning     (m_thrust_warning)
    );

endmodule

// ===== rtl/ahtc_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ahtc_checker
// Port-level checks on the result channel of the thrust controller.
// ----------------------------------------------------------------------------
module ahtc_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               m_valid,
    input logic               m_ready,
    input logic               m_level_valid,
    input logic [16:0]        m_main_level,
    input logic signed [31:0] m_max_main_acc,
    input logic               m_max_acc_valid,
    input logic               m_thrust_warning
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_main_level) && $stable(m_max_main_acc))
        else $error("result changed while stalled");

    a_level_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_main_level <= 17'd65536) && (m_level_valid || m_main_level == 17'd0))
        else $error("level out of range or set without level_valid");

    a_warn_level: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_thrust_warning |-> m_level_valid)
        else $error("warning without a level");

    a_noact: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_max_acc_valid |-> (m_max_main_acc == 32'sd0) && !m_level_valid)
        else $error("no-action item carries data");

endmodule

bind airspeed_hold_thrust_controller_core ahtc_checker u_ahtc_checker (
    .aclk             (aclk),
    .aresetn          (aresetn),
    .m_valid          (m_valid),
    .m_ready          (m_ready),
    .m_level_valid    (m_level_valid),
    .m_main_level     (m_main_level),
    .m_max_main_acc   (m_max_main_acc),
    .m_max_acc_valid  (m_max_acc_valid),
    .m_thrust_warning (m_thrust_warning)
);

// ===== tb/airspeed_hold_thrust_controller_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// airspeed_hold_thrust_controller_core_tb
// Self-checking bench for the airspeed hold thrust controller. Tick items are
// queued by a stimulus process and driven with random gaps. A local predictor
// models the hold state and computes each expected result, and a monitor
// compares every accepted result field by field, under random output stalls.
// ----------------------------------------------------------------------------
module airspeed_hold_thrust_controller_core_tb;
    import ahtc_pkg::*;

    typedef struct {
        logic        crashed;
        logic [31:0] sim_time_ms;
        logic        hold_engaged;
        logic [16:0] time_accel;
        logic        ground_contact;
        logic [30:0] gear_altitude_cm;
        logic [23:0] mass_kg;
        logic [30:0] main_thrust_max;
        logic [31:0] total_force_z;
        logic [31:0] thrust_z;
        logic [31:0] weight_lift_drag_z;
        logic [23:0] airspeed_cms;
    } tick_t;

    typedef struct {
        logic        level_valid;
        logic [16:0] main_level;
        logic [31:0] max_main_acc;
        logic        max_acc_valid;
        logic        suspended;
        logic        thrust_warning;
    } command_t;

    localparam int WATCHDOG_LIMIT = 20000;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [23:0]        cfg_wdata = '0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic               s_crashed = 1'b0;
    logic [31:0]        s_sim_time_ms = '0;
    logic               s_hold_engaged = 1'b0;
    logic [16:0]        s_time_accel = '0;
    logic               s_ground_contact = 1'b0;
    logic signed [30:0] s_gear_altitude_cm = '0;
    logic [23:0]        s_mass_kg = '0;
    logic [30:0]        s_main_thrust_max = '0;
    logic signed [31:0] s_total_force_z = '0;
    logic signed [31:0] s_thrust_z = '0;
    logic signed [31:0] s_weight_lift_drag_z = '0;
    logic [23:0]        s_airspeed_cms = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic               m_level_valid;
    logic [16:0]        m_main_level;
    logic signed [31:0] m_max_main_acc;
    logic               m_max_acc_valid;
    logic               m_suspended;
    logic               m_thrust_warning;

    tick_t       pending_ticks[$];
    command_t    expected_cmds[$];
    logic [23:0] target_cms = '0;
    logic [1:0]  hold_state = HOLD_UNSET;
    logic        suspend_state = 1'b0;
    int          errors = 0;
    int          idle_cycles = 0;
    int          gap_left = 0;
    int          stall_left = 0;
    int          holdoff_left = 0;
    bit          stim_done = 1'b0;

    // Handshakes seen at the last rising edge.
    logic s_ready_seen = 1'b0;
    logic m_ready_seen = 1'b0;

    airspeed_hold_thrust_controller_core u_dut (.*);

    initial begin
        forever #4 aclk = ~aclk;
    end

    // Advance the hold model by one tick and return the commanded result.
    function automatic command_t predict_command(tick_t t);
        command_t    c;
        longint      alt, mass, thr, net, acc, tgt, air, d, ad, mx, a, prod, n, num, den;
        longint      lim;
        longint unsigned mag;
        c = '{default: 0};
        c.suspended = suspend_state;
        if (t.crashed || t.sim_time_ms < MIN_TIME_MS) return c;
        alt  = longint'($signed(t.gear_altitude_cm));
        mass = (t.mass_kg == 0) ? 1 : longint'(t.mass_kg);
        thr  = longint'(t.main_thrust_max);
        tgt  = longint'(target_cms);
        air  = longint'(t.airspeed_cms);
        net  = (alt <= 10) ? longint'($signed(t.total_force_z)) - longint'($signed(t.thrust_z))
                           : longint'($signed(t.weight_lift_drag_z));
        acc = ((thr + net) * 1000) / mass;
        if (acc > 64'sd2147483647) acc = 64'sd2147483647;
        if (acc < -64'sd2147483648) acc = -64'sd2147483648;
        c.max_main_acc  = acc[31:0];
        c.max_acc_valid = 1'b1;
        if (t.hold_engaged && hold_state != HOLD_UNSET) begin
            if (t.time_accel > MAX_TIME_ACCEL) begin
                suspend_state = 1'b1;
                c.suspended = 1'b1;
                return c;
            end
            suspend_state = 1'b0;
            c.suspended = 1'b0;
            c.thrust_warning = (thr < -net) && (air < tgt);
            d  = tgt - air;
            ad = d < 0 ? -d : d;
            mx = ad > 1000 ? ad : 1000;
            a  = d * mx;
            mag = longint'(a < 0 ? -a : a);
            lim = 64'sd1 << 62;
            if (mag > longint'(lim) / mass) prod = a < 0 ? -lim : lim;
            else prod = a * mass;
            n = net;
            if (t.ground_contact && tgt == 0 && n < 0) n = 0;
            num = prod - n * 50000;
            if (thr == 0) c.main_level = num > 0 ? LEVEL_ONE : 17'd0;
            else begin
                den = thr * 50000;
                if (num <= 0) c.main_level = 0;
                else if (num >= den) c.main_level = LEVEL_ONE;
                else c.main_level = 17'((longint'(num) * 65536) / den);
            end
            c.level_valid = 1'b1;
        end
        hold_state = t.hold_engaged ? HOLD_ON : HOLD_OFF;
        return c;
    endfunction

    function automatic logic [31:0] rand_force();
        case ($urandom_range(0, 3))
            0: return $urandom_range(0, 20000) - 10000;
            1: return $urandom_range(0, 4000000) - 2000000;
            2: return $urandom() | 32'h8000_0000;
            default: return $urandom();
        endcase
    endfunction

    function automatic tick_t rand_tick(bit noise);
        tick_t t;
        t.crashed          = noise ? 1'($urandom_range(0, 1)) : 1'b0;
        t.sim_time_ms      = noise ? $urandom() : $urandom_range(100, 32'h7fff_ffff) | ($urandom() & 32'h8000_0000);
        t.hold_engaged     = $urandom_range(0, 9) != 0;
        t.time_accel       = $urandom_range(0, 9) == 0 ? 17'($urandom()) : 17'($urandom_range(0, 120));
        t.ground_contact   = 1'($urandom_range(0, 1));
        t.gear_altitude_cm = $urandom_range(0, 1) ? 31'($urandom_range(0, 40) - 20) : 31'($urandom());
        t.mass_kg          = $urandom_range(0, 3) == 0 ? 24'($urandom()) : 24'($urandom_range(0, 50000));
        t.main_thrust_max  = $urandom_range(0, 3) == 0 ? 31'($urandom()) : 31'($urandom_range(0, 400000));
        t.total_force_z    = rand_force();
        t.thrust_z         = rand_force();
        t.weight_lift_drag_z = rand_force();
        t.airspeed_cms     = $urandom_range(0, 1) ? 24'($urandom()) : 24'($urandom_range(0, 30000));
        return t;
    endfunction

    task automatic write_target(logic [23:0] value);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_wdata <= value;
        do @(posedge aclk); while (!cfg_ready);
        target_cms = value;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic drain_results();
        while (pending_ticks.size() != 0 || expected_cmds.size() != 0 || s_valid)
            @(posedge aclk);
        repeat (80) @(posedge aclk);
    endtask

    // Driver: present the oldest pending item after a random gap.
    always @(negedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready_seen) begin
                s_valid <= 1'b0;
                gap_left <= $urandom_range(0, 5);
            end else if (!s_valid && gap_left > 0) begin
                gap_left <= gap_left - 1;
            end else if (!s_valid && pending_ticks.size() != 0) begin
                tick_t t;
                t = pending_ticks.pop_front();
                s_crashed <= t.crashed;  s_sim_time_ms <= t.sim_time_ms;
                s_hold_engaged <= t.hold_engaged;  s_time_accel <= t.time_accel;
                s_ground_contact <= t.ground_contact;
                s_gear_altitude_cm <= t.gear_altitude_cm;
                s_mass_kg <= t.mass_kg;  s_main_thrust_max <= t.main_thrust_max;
                s_total_force_z <= t.total_force_z;  s_thrust_z <= t.thrust_z;
                s_weight_lift_drag_z <= t.weight_lift_drag_z;
                s_airspeed_cms <= t.airspeed_cms;
                s_valid <= 1'b1;
            end
            if (holdoff_left > 0) begin
                m_ready <= 1'b0;
                holdoff_left <= holdoff_left - 1;
            end else if (m_ready_seen) begin
                m_ready <= 1'b0;
                stall_left <= $urandom_range(0, 5);
            end else if (stall_left > 0) begin
                m_ready <= 1'b0;
                stall_left <= stall_left - 1;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Monitor: predict on input acceptance, check on result acceptance.
    always @(posedge aclk) begin
        command_t exp_c;
        s_ready_seen <= aresetn && s_valid && s_ready;
        m_ready_seen <= aresetn && m_valid && m_ready;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                tick_t t;
                t.crashed = s_crashed;  t.sim_time_ms = s_sim_time_ms;
                t.hold_engaged = s_hold_engaged;  t.time_accel = s_time_accel;
                t.ground_contact = s_ground_contact;
                t.gear_altitude_cm = s_gear_altitude_cm;
                t.mass_kg = s_mass_kg;  t.main_thrust_max = s_main_thrust_max;
                t.total_force_z = s_total_force_z;  t.thrust_z = s_thrust_z;
                t.weight_lift_drag_z = s_weight_lift_drag_z;
                t.airspeed_cms = s_airspeed_cms;
                expected_cmds.push_back(predict_command(t));
            end
            if (m_valid && m_ready) begin
                if (expected_cmds.size() == 0) begin
                    $error("unexpected result item");
                    errors++;
                end else begin
                    exp_c = expected_cmds.pop_front();
                    if (m_level_valid !== exp_c.level_valid) begin
                        $error("level_valid: expected %0d actual %0d", exp_c.level_valid, m_level_valid);
                        errors++;
                    end
                    if (m_main_level !== exp_c.main_level) begin
                        $error("main_level: expected %0d actual %0d", exp_c.main_level, m_main_level);
                        errors++;
                    end
                    if (m_max_main_acc !== exp_c.max_main_acc) begin
                        $error("max_main_acc: expected %0d actual %0d",
                               $signed(exp_c.max_main_acc), m_max_main_acc);
                        errors++;
                    end
                    if (m_max_acc_valid !== exp_c.max_acc_valid) begin
                        $error("max_acc_valid: expected %0d actual %0d", exp_c.max_acc_valid, m_max_acc_valid);
                        errors++;
                    end
                    if (m_suspended !== exp_c.suspended) begin
                        $error("suspended: expected %0d actual %0d", exp_c.suspended, m_suspended);
                        errors++;
                    end
                    if (m_thrust_warning !== exp_c.thrust_warning) begin
                        $error("thrust_warning: expected %0d actual %0d",
                               exp_c.thrust_warning, m_thrust_warning);
                        errors++;
                    end
                end
            end
            if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    initial begin
        tick_t t;
        logic [23:0] targets[5];
        targets = '{24'd0, 24'hFFFFFF, 24'd2500, 24'd15000, 24'd0};
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        write_target(24'd10000);
        // Directed: no-action ticks, first tick with hold state unset, suspend, extremes.
        t = rand_tick(0);
        t.hold_engaged = 1; t.time_accel = 0; t.crashed = 1;
        pending_ticks.push_back(t);
        t.crashed = 0; t.sim_time_ms = 99;
        pending_ticks.push_back(t);
        t.sim_time_ms = 100;
        pending_ticks.push_back(t);
        t.time_accel = 17'h1FFFF;
        pending_ticks.push_back(t);
        t.time_accel = 100;
        pending_ticks.push_back(t);
        t.time_accel = 101;
        pending_ticks.push_back(t);
        t.time_accel = 1; t.mass_kg = 0; t.main_thrust_max = 0;
        pending_ticks.push_back(t);
        t.mass_kg = 24'hFFFFFF; t.main_thrust_max = 31'h7FFFFFFF;
        t.gear_altitude_cm = 31'sh40000000; t.weight_lift_drag_z = 32'h80000000;
        pending_ticks.push_back(t);
        t.mass_kg = 1; t.weight_lift_drag_z = 32'h7FFFFFFF; t.airspeed_cms = 24'hFFFFFF;
        pending_ticks.push_back(t);
        t.gear_altitude_cm = 10; t.total_force_z = 32'h80000000; t.thrust_z = 32'h7FFFFFFF;
        t.airspeed_cms = 0; t.main_thrust_max = 5;
        pending_ticks.push_back(t);
        t.gear_altitude_cm = 11; t.hold_engaged = 0;
        pending_ticks.push_back(t);
        t.sim_time_ms = 32'hFFFFFFFF; t.hold_engaged = 1;
        pending_ticks.push_back(t);
        drain_results();
        // Ground hold at zero target.
        write_target(24'd0);
        t = rand_tick(0);
        t.hold_engaged = 1; t.time_accel = 1; t.ground_contact = 1;
        t.gear_altitude_cm = 0; t.total_force_z = -5000; t.thrust_z = 0;
        t.main_thrust_max = 100000; t.mass_kg = 10000; t.airspeed_cms = 0;
        repeat (3) pending_ticks.push_back(t);
        t.main_thrust_max = 0;
        pending_ticks.push_back(t);
        drain_results();
        for (int p = 0; p < 5; p++) begin
            write_target(p == 4 ? 24'($urandom()) : targets[p]);
            for (int i = 0; i < 110; i++) begin
                while (pending_ticks.size() > 4) @(posedge aclk);
                pending_ticks.push_back(rand_tick($urandom_range(0, 9) == 0));
                if (p == 2 && i == 40) holdoff_left = 600;
            end
            drain_results();
        end
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/ahtc_pkg.sv
rtl/ahtc_ctrl.sv
rtl/ahtc_dpath.sv
rtl/airspeed_hold_thrust_controller_core.sv
rtl/ahtc_checker.sv
tb/airspeed_hold_thrust_controller_core_tb.sv
